// File: rtl/v3n_pkg.sv
package v3n_pkg;

    localparam int IN_WIDTH_DEF = 16;
    localparam int OUT_FRAC_DEF = 14;
    localparam int MAG_FRAC_BITS = 8;
    localparam int LANES = 3;

endpackage

// File: rtl/v3n_sqrt_cell.sv
module v3n_sqrt_cell #(
    parameter int IN_WIDTH = v3n_pkg::IN_WIDTH_DEF,
    parameter int SBW      = 4 + 3 * v3n_pkg::IN_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  logic                                      i_vld,
    input  logic [2*IN_WIDTH+2*v3n_pkg::MAG_FRAC_BITS-1:0] i_rad,
    input  logic [IN_WIDTH+v3n_pkg::MAG_FRAC_BITS+2:0]     i_rem,
    input  logic [IN_WIDTH+v3n_pkg::MAG_FRAC_BITS-1:0]     i_root,
    input  logic [SBW-1:0]                            i_sb,
    output logic                                      o_vld,
    output logic [2*IN_WIDTH+2*v3n_pkg::MAG_FRAC_BITS-1:0] o_rad,
    output logic [IN_WIDTH+v3n_pkg::MAG_FRAC_BITS+2:0]     o_rem,
    output logic [IN_WIDTH+v3n_pkg::MAG_FRAC_BITS-1:0]     o_root,
    output logic [SBW-1:0]                            o_sb
);
    localparam int MW   = IN_WIDTH + v3n_pkg::MAG_FRAC_BITS;
    localparam int RW   = MW + 3;
    localparam int RADW = 2 * IN_WIDTH + 2 * v3n_pkg::MAG_FRAC_BITS;

    logic [RW-1:0]   rem_sh;
    logic [RW-1:0]   trial;
    logic            take;
    logic [RW-1:0]   n_rem;
    logic [MW-1:0]   n_root;
    logic [RADW-1:0] n_rad;

    logic            r_vld;
    logic [RADW-1:0] r_rad;
    logic [RW-1:0]   r_rem;
    logic [MW-1:0]   r_root;
    logic [SBW-1:0]  r_sb;

    always_comb begin
        rem_sh = {i_rem[RW-3:0], i_rad[RADW-1 -: 2]};
        trial  = {1'b0, i_root, 2'b01};
        take   = (rem_sh >= trial);
        n_rem  = take ? (rem_sh - trial) : rem_sh;
        n_root = {i_root[MW-2:0], take};
        n_rad  = {i_rad[RADW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_sb   <= i_sb;
        end
    end

    assign o_vld  = r_vld;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_sb   = r_sb;

endmodule

// File: rtl/v3n_div_cell.sv
module v3n_div_cell #(
    parameter int IN_WIDTH = v3n_pkg::IN_WIDTH_DEF,
    parameter int OUT_FRAC = v3n_pkg::OUT_FRAC_DEF
) (
    input  logic                                                     i_clk,
    input  logic                                                     i_rst_n,
    input  logic                                                     i_en,
    input  logic                                                     i_vld,
    input  logic [IN_WIDTH+v3n_pkg::MAG_FRAC_BITS-1:0]                 i_m,
    input  logic [v3n_pkg::LANES-1:0][IN_WIDTH+v3n_pkg::MAG_FRAC_BITS-1:0] i_rem,
    input  logic [v3n_pkg::LANES-1:0][OUT_FRAC+v3n_pkg::MAG_FRAC_BITS-1:0] i_q,
    input  logic [v3n_pkg::LANES:0]                                  i_sb,
    output logic                                                     o_vld,
    output logic [IN_WIDTH+v3n_pkg::MAG_FRAC_BITS-1:0]                 o_m,
    output logic [v3n_pkg::LANES-1:0][IN_WIDTH+v3n_pkg::MAG_FRAC_BITS-1:0] o_rem,
    output logic [v3n_pkg::LANES-1:0][OUT_FRAC+v3n_pkg::MAG_FRAC_BITS-1:0] o_q,
    output logic [v3n_pkg::LANES:0]                                  o_sb
);
    localparam int MW = IN_WIDTH + v3n_pkg::MAG_FRAC_BITS;
    localparam int QW = OUT_FRAC + v3n_pkg::MAG_FRAC_BITS;
    localparam int L  = v3n_pkg::LANES;

    logic [L-1:0][MW:0]   rem2;
    logic [L-1:0]         take;
    logic [L-1:0][MW-1:0] n_rem;
    logic [L-1:0][QW-1:0] n_q;

    logic                 r_vld;
    logic [MW-1:0]        r_m;
    logic [L-1:0][MW-1:0] r_rem;
    logic [L-1:0][QW-1:0] r_q;
    logic [L:0]           r_sb;

    always_comb begin
        for (int k = 0; k < L; k++) begin
            rem2[k]  = {i_rem[k], 1'b0};
            take[k]  = (rem2[k] >= {1'b0, i_m});
            n_rem[k] = take[k] ? MW'(rem2[k] - {1'b0, i_m}) : rem2[k][MW-1:0];
            n_q[k]   = {i_q[k][QW-2:0], take[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m   <= i_m;
            r_rem <= n_rem;
            r_q   <= n_q;
            r_sb  <= i_sb;
        end
    end

    assign o_vld = r_vld;
    assign o_m   = r_m;
    assign o_rem = r_rem;
    assign o_q   = r_q;
    assign o_sb  = r_sb;

endmodule

// File: rtl/vector3_normalize_core.sv
// channel | valid        | ready        | payload
// in      | i_in_valid   | o_in_ready   | i_in_x, i_in_y, i_in_z
// out     | o_out_valid  | i_out_ready  | o_unit_x/y/z, o_magnitude, o_zero_length
//
// One transfer per cycle while the output is not held. Stages, in order:
// abs, square and sum stages, one square-root cell per root bit (IN_WIDTH + 8),
// one divide cell per quotient bit (OUT_FRAC + 8), then the output register.
// Synchronous active-low reset clears the valid bits only.
// A held output stalls the whole chain; o_in_ready follows that stall.
module vector3_normalize_core #(
    parameter int IN_WIDTH = v3n_pkg::IN_WIDTH_DEF,
    parameter int OUT_FRAC = v3n_pkg::OUT_FRAC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [IN_WIDTH-1:0]   i_in_x,
    input  logic [IN_WIDTH-1:0]   i_in_y,
    input  logic [IN_WIDTH-1:0]   i_in_z,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_FRAC+1:0]   o_unit_x,
    output logic [OUT_FRAC+1:0]   o_unit_y,
    output logic [OUT_FRAC+1:0]   o_unit_z,
    output logic [IN_WIDTH+7:0]   o_magnitude,
    output logic                  o_zero_length
);
    localparam int L    = v3n_pkg::LANES;
    localparam int MW   = IN_WIDTH + v3n_pkg::MAG_FRAC_BITS;
    localparam int RW   = MW + 3;
    localparam int SW   = 2 * IN_WIDTH;
    localparam int RADW = SW + 2 * v3n_pkg::MAG_FRAC_BITS;
    localparam int QW   = OUT_FRAC + v3n_pkg::MAG_FRAC_BITS;
    localparam int UW   = OUT_FRAC + 2;
    localparam int NS   = MW;
    localparam int ND   = QW;
    localparam int SBW  = 1 + L + L * IN_WIDTH;

    logic en;
    logic [L-1:0][IN_WIDTH-1:0] in_v;

    logic                       r_a_vld, r_b_vld, r_c_vld;
    logic                       r_a_zero, r_b_zero, r_c_zero;
    logic [L-1:0][IN_WIDTH-1:0] r_a_abs, r_b_abs, r_c_abs;
    logic [L-1:0]               r_a_neg, r_b_neg, r_c_neg;
    logic [L-1:0][SW-1:0]       r_b_sq;
    logic [SW-1:0]              r_c_sum;

    logic [NS:0]                s_vld;
    logic [NS:0][RADW-1:0]      s_rad;
    logic [NS:0][RW-1:0]        s_rem;
    logic [NS:0][MW-1:0]        s_root;
    logic [NS:0][SBW-1:0]       s_sb;

    logic [ND:0]                d_vld;
    logic [ND:0][MW-1:0]        d_m;
    logic [ND:0][L-1:0][MW-1:0] d_rem;
    logic [ND:0][L-1:0][QW-1:0] d_q;
    logic [ND:0][L:0]           d_sb;

    logic [L-1:0][IN_WIDTH-1:0] f_abs;
    logic [L-1:0]               f_neg;
    logic                       f_zero;
    logic [L-1:0][UW-1:0]       n_unit;
    logic [UW-1:0]              qc;

    logic                       r_out_valid;
    logic [L-1:0][UW-1:0]       r_unit;
    logic [MW-1:0]              r_mag;
    logic                       r_zero;

    assign en         = ~r_out_valid | i_out_ready;
    assign o_in_ready = en;
    assign in_v       = {i_in_z, i_in_y, i_in_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_c_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_vld     <= i_in_valid;
            r_b_vld     <= r_a_vld;
            r_c_vld     <= r_b_vld;
            r_out_valid <= d_vld[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < L; k++) begin
                r_a_neg[k] <= in_v[k][IN_WIDTH-1];
                r_a_abs[k] <= in_v[k][IN_WIDTH-1] ? (~in_v[k] + 1'b1) : in_v[k];
                r_b_sq[k]  <= {{IN_WIDTH{1'b0}}, r_a_abs[k]} * {{IN_WIDTH{1'b0}}, r_a_abs[k]};
            end
            r_a_zero <= (in_v == '0);
            r_b_abs  <= r_a_abs;
            r_b_neg  <= r_a_neg;
            r_b_zero <= r_a_zero;
            r_c_sum  <= SW'({2'b00, r_b_sq[0]} + {2'b00, r_b_sq[1]} + {2'b00, r_b_sq[2]});
            r_c_abs  <= r_b_abs;
            r_c_neg  <= r_b_neg;
            r_c_zero <= r_b_zero;
            r_unit   <= n_unit;
            r_mag    <= d_m[ND];
            r_zero   <= d_sb[ND][L];
        end
    end

    assign s_vld[0]  = r_c_vld;
    assign s_rad[0]  = {r_c_sum, {(2 * v3n_pkg::MAG_FRAC_BITS){1'b0}}};
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_sb[0]   = {r_c_zero, r_c_neg, r_c_abs};

    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        v3n_sqrt_cell #(
            .IN_WIDTH (IN_WIDTH),
            .SBW      (SBW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (s_vld[g]),
            .i_rad   (s_rad[g]),
            .i_rem   (s_rem[g]),
            .i_root  (s_root[g]),
            .i_sb    (s_sb[g]),
            .o_vld   (s_vld[g+1]),
            .o_rad   (s_rad[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_root  (s_root[g+1]),
            .o_sb    (s_sb[g+1])
        );
    end

    assign f_abs  = s_sb[NS][L*IN_WIDTH-1:0];
    assign f_neg  = s_sb[NS][L*IN_WIDTH +: L];
    assign f_zero = s_sb[NS][SBW-1];

    assign d_vld[0] = s_vld[NS];
    assign d_m[0]   = s_root[NS];
    assign d_sb[0]  = {f_zero, f_neg};
    for (genvar k = 0; k < L; k++) begin : g_div_in
        assign d_rem[0][k] = MW'(f_abs[k]);
        assign d_q[0][k]   = '0;
    end

    for (genvar g = 0; g < ND; g++) begin : g_div
        v3n_div_cell #(
            .IN_WIDTH (IN_WIDTH),
            .OUT_FRAC (OUT_FRAC)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (d_vld[g]),
            .i_m     (d_m[g]),
            .i_rem   (d_rem[g]),
            .i_q     (d_q[g]),
            .i_sb    (d_sb[g]),
            .o_vld   (d_vld[g+1]),
            .o_m     (d_m[g+1]),
            .o_rem   (d_rem[g+1]),
            .o_q     (d_q[g+1]),
            .o_sb    (d_sb[g+1])
        );
    end

    // clamp to one, apply sign, force zero for the zero vector
    always_comb begin
        qc = '0;
        for (int k = 0; k < L; k++) begin
            if (d_q[ND][k] > QW'(1) << OUT_FRAC) begin
                qc = UW'(1) << OUT_FRAC;
            end else begin
                qc = UW'(d_q[ND][k]);
            end
            if (d_sb[ND][L]) begin
                n_unit[k] = '0;
            end else if (d_sb[ND][k]) begin
                n_unit[k] = ~qc + 1'b1;
            end else begin
                n_unit[k] = qc;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_unit_x      = r_unit[0];
    assign o_unit_y      = r_unit[1];
    assign o_unit_z      = r_unit[2];
    assign o_magnitude   = r_mag;
    assign o_zero_length = r_zero;

endmodule
